### design/tdp_pkg.sv
// shared types, widths and state encoding for the trial division prime unit
`default_nettype none

package tdp_pkg;

    localparam int OPERAND_BITS = 16;
    // largest candidate reached when summing 2^16-1 primes stays below 2^20
    localparam int CAND_BITS    = 20;
    localparam int DIV_BITS     = (CAND_BITS / 2) + 1;
    localparam int REM_BITS     = DIV_BITS + 1;
    localparam int DSQ_BITS     = 2 * DIV_BITS;
    localparam int SUM_BITS     = 35;
    localparam int BITCNT_BITS  = $clog2(CAND_BITS);

    localparam logic CMD_TEST = 1'b0;
    localparam logic CMD_SUM  = 1'b1;

    typedef struct packed {
        logic                    command;
        logic [OPERAND_BITS-1:0] operand;
    } t_in_word;

    typedef struct packed {
        logic                prime_flag;
        logic [SUM_BITS-1:0] prime_sum;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_BOUND,
        S_DIV,
        S_REM,
        S_RESULT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic test_init;
        logic div_start;
        logic div_step;
        logic next_div;
        logic set_prime;
        logic clr_prime;
        logic advance;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic sum_mode;
        logic count_done;
        logic cand_small;
        logic bound_passed;
        logic div_last;
        logic rem_zero;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

### design/tdp_datapath.sv
// datapath: candidate, divisor, bit-serial remainder, prime count, sum and output register
`default_nettype none

module tdp_datapath import tdp_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_dp_cmd   i_cmd,
    input  wire t_in_word  i_in_word,
    input  wire logic      i_out_ready,
    output t_dp_sts        o_sts,
    output logic           o_out_valid,
    output t_out_word      o_out_word
);

    logic                    r_mode, n_mode;
    logic [OPERAND_BITS-1:0] r_count, n_count;
    logic [OPERAND_BITS-1:0] r_found, n_found;
    logic [CAND_BITS-1:0]    r_cand, n_cand;
    logic [DIV_BITS-1:0]     r_div, n_div;
    logic [DSQ_BITS-1:0]     r_dsq, n_dsq;
    logic [REM_BITS-1:0]     r_rem, n_rem;
    logic [BITCNT_BITS-1:0]  r_bitcnt, n_bitcnt;
    logic [SUM_BITS-1:0]     r_sum, n_sum;
    logic                    r_is_prime, n_is_prime;
    logic                    r_out_valid, n_out_valid;
    t_out_word               r_out_word, n_out_word;

    logic [BITCNT_BITS-1:0]  bit_idx;
    logic [REM_BITS-1:0]     rem_shift;

    // one quotient bit per cycle, candidate msb first
    assign bit_idx   = BITCNT_BITS'(CAND_BITS - 1) - r_bitcnt;
    assign rem_shift = {r_rem[REM_BITS-2:0], r_cand[bit_idx]};

    always_comb begin
        n_mode      = r_mode;
        n_count     = r_count;
        n_found     = r_found;
        n_cand      = r_cand;
        n_div       = r_div;
        n_dsq       = r_dsq;
        n_rem       = r_rem;
        n_bitcnt    = r_bitcnt;
        n_sum       = r_sum;
        n_is_prime  = r_is_prime;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;

        if (i_cmd.load) begin
            n_mode  = i_in_word.command;
            n_count = i_in_word.operand;
            n_found = '0;
            n_sum   = '0;
            if (i_in_word.command == CMD_SUM) begin
                n_cand = CAND_BITS'(2);
            end else begin
                n_cand = CAND_BITS'(i_in_word.operand);
            end
        end

        if (i_cmd.test_init) begin
            n_div = DIV_BITS'(2);
            n_dsq = DSQ_BITS'(4);
        end

        if (i_cmd.div_start) begin
            n_rem    = '0;
            n_bitcnt = '0;
        end

        if (i_cmd.div_step) begin
            if (rem_shift >= {1'b0, r_div}) begin
                n_rem = rem_shift - {1'b0, r_div};
            end else begin
                n_rem = rem_shift;
            end
            n_bitcnt = r_bitcnt + 1'b1;
        end

        // (d+1)^2 = d^2 + 2d + 1
        if (i_cmd.next_div) begin
            n_div = r_div + 1'b1;
            n_dsq = r_dsq + DSQ_BITS'({r_div, 1'b1});
        end

        if (i_cmd.set_prime) begin
            n_is_prime = 1'b1;
        end
        if (i_cmd.clr_prime) begin
            n_is_prime = 1'b0;
        end

        if (i_cmd.advance) begin
            if (r_is_prime) begin
                n_sum   = r_sum + SUM_BITS'(r_cand);
                n_found = r_found + 1'b1;
            end
            n_cand = r_cand + 1'b1;
        end

        if (i_cmd.out_load) begin
            n_out_valid           = 1'b1;
            n_out_word.prime_flag = (r_mode == CMD_TEST) && r_is_prime;
            n_out_word.prime_sum  = (r_mode == CMD_SUM) ? r_sum : '0;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= CMD_TEST;
            r_count     <= '0;
            r_found     <= '0;
            r_cand      <= '0;
            r_div       <= '0;
            r_dsq       <= '0;
            r_rem       <= '0;
            r_bitcnt    <= '0;
            r_sum       <= '0;
            r_is_prime  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_count     <= n_count;
            r_found     <= n_found;
            r_cand      <= n_cand;
            r_div       <= n_div;
            r_dsq       <= n_dsq;
            r_rem       <= n_rem;
            r_bitcnt    <= n_bitcnt;
            r_sum       <= n_sum;
            r_is_prime  <= n_is_prime;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

    assign o_sts.sum_mode     = (r_mode == CMD_SUM);
    assign o_sts.count_done   = (r_found == r_count);
    assign o_sts.cand_small   = (r_cand < CAND_BITS'(2));
    assign o_sts.bound_passed = (DSQ_BITS'(r_cand) < r_dsq);
    assign o_sts.div_last     = (r_bitcnt == BITCNT_BITS'(CAND_BITS - 1));
    assign o_sts.rem_zero     = (r_rem == '0);
    assign o_sts.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |=> ({1'b0, r_div} > r_rem))
        else $error("remainder not below divisor after division step");

    a_dsq_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dsq == DSQ_BITS'(r_div) * DSQ_BITS'(r_div))
        else $error("divisor square out of step with divisor");

    a_found_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == CMD_SUM) |-> (r_found <= r_count))
        else $error("prime count passed requested count");

    a_out_free_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> o_sts.out_free)
        else $error("output word loaded over a pending word");
`endif

endmodule

`default_nettype wire

### design/tdp_ctrl.sv
// controller state machine sequencing candidates, divisors and division steps
`default_nettype none

module tdp_ctrl import tdp_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_TEST;
                end
            end
            S_TEST: begin
                if (i_sts.sum_mode && i_sts.count_done) begin
                    n_state = S_DONE;
                end else if (i_sts.cand_small) begin
                    o_cmd.clr_prime = 1'b1;
                    n_state         = S_RESULT;
                end else begin
                    o_cmd.test_init = 1'b1;
                    n_state         = S_BOUND;
                end
            end
            S_BOUND: begin
                // divisor squared beyond candidate: no factor left
                if (i_sts.bound_passed) begin
                    o_cmd.set_prime = 1'b1;
                    n_state         = S_RESULT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_REM;
                end
            end
            S_REM: begin
                if (i_sts.rem_zero) begin
                    o_cmd.clr_prime = 1'b1;
                    n_state         = S_RESULT;
                end else begin
                    o_cmd.next_div = 1'b1;
                    n_state        = S_BOUND;
                end
            end
            S_RESULT: begin
                if (i_sts.sum_mode) begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_TEST;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/trial_division_prime_unit_top.sv
// a test of n runs a full bit-serial division for every divisor tried, up to sqrt(n); the
// bit-serial remainder sets the pace
// sum of k primes repeats that test for every candidate up to the k-th prime
// one word in flight; the next word is taken while the last
// result waits in the output register
// synchronous active-low reset returns the controller to idle and drops the output valid
`default_nettype none

module trial_division_prime_unit_top import tdp_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_word
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    tdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    tdp_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_in_word   (i_in_word),
        .i_out_ready (i_out_ready),
        .o_sts       (dp_sts),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

### tb/tb_trial_division_prime_unit_top.sv
// self-checking testbench for the trial division prime unit: primality tests and prime sums
`default_nettype none

module tb_trial_division_prime_unit_top import tdp_pkg::*; ;

    localparam int          RESET_CYCLES   = 12;
    localparam int          RANDOM_WORDS   = 120;
    localparam int          HOLD_OFF_AFTER = 40;
    localparam int          HOLD_OFF_LEN   = 4000;
    localparam int          DRAIN_CYCLES   = 200;
    localparam int          WATCHDOG_LIMIT = 600000;
    localparam int unsigned LARGEST_PRIME  = 65521;

    class prime_scoreboard;
        t_out_word   awaited_results[$];
        int unsigned mismatches;

        static function bit trial_is_prime(int unsigned v);
            int unsigned d;
            if (v < 2) return 1'b0;
            for (d = 2; d * d <= v; d++) begin
                if (v % d == 0) return 1'b0;
            end
            return 1'b1;
        endfunction

        static function logic [SUM_BITS-1:0] first_primes_sum(int unsigned count);
            longint unsigned acc;
            int unsigned     found;
            int unsigned     cand;
            acc   = 0;
            found = 0;
            cand  = 2;
            while (found < count) begin
                if (trial_is_prime(cand)) begin
                    acc += cand;
                    found++;
                end
                cand++;
            end
            return acc[SUM_BITS-1:0];
        endfunction

        function void note_word(t_in_word w);
            t_out_word want;
            want = '0;
            if (w.command == CMD_TEST) begin
                want.prime_flag = trial_is_prime(w.operand);
            end else begin
                want.prime_sum = first_primes_sum(w.operand);
            end
            awaited_results.push_back(want);
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (awaited_results.size() == 0) begin
                $error("unexpected output word: prime_flag %0d prime_sum %0d",
                       got.prime_flag, got.prime_sum);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            if (got.prime_flag !== want.prime_flag) begin
                $error("prime_flag: expected %0d, actual %0d", want.prime_flag, got.prime_flag);
                mismatches++;
            end
            if (got.prime_sum !== want.prime_sum) begin
                $error("prime_sum: expected %0d, actual %0d", want.prime_sum, got.prime_sum);
                mismatches++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_word;

    prime_scoreboard board = new();
    int              results_seen = 0;
    int              idle_cycles  = 0;

    trial_division_prime_unit_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    function automatic logic [OPERAND_BITS-1:0] prime_at_or_above(int unsigned v);
        int unsigned c;
        if (v > LARGEST_PRIME) return LARGEST_PRIME[OPERAND_BITS-1:0];
        c = v;
        while (!prime_scoreboard::trial_is_prime(c)) c++;
        return c[OPERAND_BITS-1:0];
    endfunction

    task automatic send_word(input logic cmd, input logic [OPERAND_BITS-1:0] opnd,
                             input int gap);
        t_in_word w;
        w.command = cmd;
        w.operand = opnd;
        i_in_word  <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_word(w);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random_word(input int gap);
        logic [OPERAND_BITS-1:0] opnd;
        logic [OPERAND_BITS-1:0] p;
        int                      r;
        r = $urandom_range(0, 9);
        if ($urandom_range(0, 4) == 0) begin
            // sum cost grows fast with the count, so keep it modest
            if ($urandom_range(0, 7) == 0) opnd = OPERAND_BITS'($urandom_range(41, 70));
            else opnd = OPERAND_BITS'($urandom_range(0, 40));
            send_word(CMD_SUM, opnd, gap);
        end else begin
            if (r < 4) begin
                opnd = OPERAND_BITS'($urandom_range(0, 65535));
            end else if (r < 7) begin
                opnd = prime_at_or_above($urandom_range(0, 65535));
            end else if (r < 9) begin
                opnd = OPERAND_BITS'($urandom_range(0, 300));
            end else begin
                // square of a prime lands right on the divisor bound
                p    = prime_at_or_above($urandom_range(2, 251));
                opnd = p * p;
            end
            send_word(CMD_TEST, opnd, gap);
        end
    endtask

    initial begin : stimulus
        int i;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_word  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(CMD_TEST, 16'd0,     pick_gap());
        send_word(CMD_TEST, 16'd1,     pick_gap());
        send_word(CMD_TEST, 16'd2,     pick_gap());
        send_word(CMD_TEST, 16'd3,     pick_gap());
        send_word(CMD_TEST, 16'd4,     pick_gap());
        send_word(CMD_TEST, 16'd9,     pick_gap());
        send_word(CMD_TEST, 16'd25,    pick_gap());
        send_word(CMD_TEST, 16'd49,    pick_gap());
        send_word(CMD_TEST, 16'd63001, pick_gap());
        send_word(CMD_TEST, 16'd32768, pick_gap());
        send_word(CMD_TEST, 16'h5555,  pick_gap());
        send_word(CMD_TEST, 16'hAAAA,  pick_gap());
        send_word(CMD_TEST, 16'd65521, pick_gap());
        send_word(CMD_TEST, 16'd65535, pick_gap());
        send_word(CMD_SUM,  16'd0,     pick_gap());
        send_word(CMD_SUM,  16'd1,     pick_gap());
        send_word(CMD_SUM,  16'd2,     pick_gap());
        send_word(CMD_SUM,  16'd3,     pick_gap());
        send_word(CMD_SUM,  16'd10,    pick_gap());
        send_word(CMD_SUM,  16'd100,   pick_gap());

        for (i = 0; i < RANDOM_WORDS; i++) begin
            // back-to-back stretch in the middle
            if (i >= 50 && i < 70) send_random_word(0);
            else send_random_word(pick_gap());
        end
        i_in_valid <= 1'b0;

        while (board.awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("tb_trial_division_prime_unit_top: clean");
        end else begin
            $display("tb_trial_division_prime_unit_top: errors");
        end
        $finish;
    end

    initial begin : receiver
        int low_run;
        int high_run;
        bit held_off;
        held_off = 1'b0;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            // one long hold-off so the unit fills and stalls its input
            if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge i_clk);
            end
            low_run = pick_gap();
            if (low_run > 0) begin
                i_out_ready <= 1'b0;
                repeat (low_run) @(posedge i_clk);
            end
            if ($urandom_range(0, 19) == 0) high_run = $urandom_range(500, 3000);
            else high_run = $urandom_range(1, 30);
            i_out_ready <= 1'b1;
            repeat (high_run) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_word(o_out_word);
            results_seen <= results_seen + 1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_trial_division_prime_unit_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

`default_nettype wire
